// File: design/emos_pkg.sv
// Shared types and constants for the E-model MOS estimator.
// No dependencies; used by every module of the block.
package emos_pkg;

  localparam int DELAY_W   = 22;
  localparam int LOSS_W    = 17;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;
  localparam int RATING_W  = 19;
  localparam int MOS_W     = 13;
  localparam int ID_W      = 18;
  localparam int QUO_W     = 15;
  localparam int NUM_W     = 38;
  localparam int DEN_W     = 24;
  localparam int DIV_STEPS = QUO_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EQUIP_IMP = 2'd0,
    CFG_LOSS_ROB  = 2'd1,
    CFG_ADVANTAGE = 2'd2,
    CFG_BASE_RATE = 2'd3
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] IE_RESET   = 15'd1280;
  localparam logic [CFG_W-1:0] BPL_RESET  = 15'd2560;
  localparam logic [12:0]      ADV_RESET  = 13'd1280;
  localparam logic [CFG_W-1:0] RO_RESET   = 15'd23859;

  localparam logic [CFG_W-1:0]   IMP_CEIL_Q8 = 15'd24320;
  localparam logic [CFG_W-1:0]   BPL_MIN_Q8  = 15'd256;
  localparam logic [LOSS_W-1:0]  LOSS_FULL   = 17'd65536;
  localparam logic [DELAY_W-1:0] KNEE_US     = 22'd177300;
  localparam logic [31:0]        ID_ROUND    = 32'd7812;
  localparam logic [32:0]        ID_RECIP    = 33'd4503599628;

  localparam logic signed [20:0] RATING_MIN = -21'sd200000;
  localparam logic signed [20:0] RATING_MAX = 21'sd40000;

  localparam logic signed [RATING_W-1:0] R_TOP_Q8 = 19'sd25600;
  localparam logic signed [15:0] R_SIXTY_Q8 = 16'sd15360;
  localparam logic [15:0]        R_TOP_U16  = 16'd25600;
  localparam logic [31:0]        MOS_LIN_K  = 32'd2293760000;
  localparam logic [33:0]        MOS_HALF_DEN = 34'd8192000000;
  localparam logic [26:0]        MOS_RECIP  = 27'd70368745;
  localparam logic [MOS_W-1:0]   MOS_ONE_Q10 = 13'd1024;
  localparam logic [MOS_W-1:0]   MOS_TOP_Q10 = 13'd4608;

  typedef struct packed {
    logic [DELAY_W-1:0] delay_us;
    logic [LOSS_W-1:0]  loss_frac_q16;
  } in_t;

  typedef struct packed {
    logic signed [RATING_W-1:0] rating_q8;
    logic [MOS_W-1:0]           mos_q10;
  } out_t;

  typedef struct packed {
    logic [ID_W-1:0] id_q8;
    logic            ie_neg;
  } div_tag_t;

endpackage

// File: design/emos_ie_div.sv
// Pipelined restoring divider for the loss share of the equipment impairment.
// One quotient bit per stage; depends on emos_pkg.
module emos_ie_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [emos_pkg::NUM_W-1:0]    in_num,
  input  logic [emos_pkg::DEN_W-1:0]    in_den,
  input  emos_pkg::div_tag_t            in_tag,
  output logic                          out_vld,
  output logic [emos_pkg::QUO_W-1:0]    out_quo,
  output emos_pkg::div_tag_t            out_tag
);

  logic                          vld_r [0:emos_pkg::DIV_STEPS];
  logic [emos_pkg::NUM_W-1:0]    rem_r [0:emos_pkg::DIV_STEPS];
  logic [emos_pkg::DEN_W-1:0]    den_r [0:emos_pkg::DIV_STEPS];
  logic [emos_pkg::QUO_W-1:0]    quo_r [0:emos_pkg::DIV_STEPS];
  emos_pkg::div_tag_t            tag_r [0:emos_pkg::DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    rem_r[0] <= in_num;
    den_r[0] <= in_den;
    quo_r[0] <= '0;
    tag_r[0] <= in_tag;
  end

  for (genvar s = 0; s < emos_pkg::DIV_STEPS; s++) begin : g_step
    localparam int SH = emos_pkg::DIV_STEPS - 1 - s;
    logic [emos_pkg::NUM_W:0] trial;
    logic [emos_pkg::NUM_W:0] diff;
    logic                     take;

    assign trial = (emos_pkg::NUM_W+1)'(den_r[s]) << SH;
    assign diff  = {1'b0, rem_r[s]} - trial;
    assign take  = ({1'b0, rem_r[s]} >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
      rem_r[s+1] <= take ? diff[emos_pkg::NUM_W-1:0] : rem_r[s];
      den_r[s+1] <= den_r[s];
      quo_r[s+1] <= {quo_r[s][emos_pkg::QUO_W-2:0], take};
      tag_r[s+1] <= tag_r[s];
    end
  end

  assign out_vld = vld_r[emos_pkg::DIV_STEPS];
  assign out_quo = quo_r[emos_pkg::DIV_STEPS];
  assign out_tag = tag_r[emos_pkg::DIV_STEPS];

endmodule

// File: design/emos_mos.sv
// Rating to mean opinion score pipeline: cubic, exact scaling, clamping.
// Five register stages; depends on emos_pkg.
module emos_mos (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_vld,
  input  logic signed [emos_pkg::RATING_W-1:0] in_rating,
  output logic                                 out_vld,
  output emos_pkg::out_t                       out_res
);

  logic [14:0]        rr_w;
  logic signed [15:0] a_w;
  logic signed [31:0] p1_w;
  logic [15:0]        b_w;

  logic                                 va_r, lowa_r, higha_r;
  logic signed [emos_pkg::RATING_W-1:0] rata_r;
  logic [14:0]                          rra_r;
  logic signed [31:0]                   p1a_r;
  logic [15:0]                          ba_r;

  logic                                 vb_r, lowb_r, highb_r;
  logic signed [emos_pkg::RATING_W-1:0] ratb_r;
  logic signed [47:0]                   p2b_r;
  logic [45:0]                          linb_r;

  logic signed [48:0] t_w;
  logic signed [48:0] u_w;

  logic                                 vc_r, lowc_r, highc_r;
  logic signed [emos_pkg::RATING_W-1:0] ratc_r;
  logic [25:0]                          vq_r;

  logic                                 vd_r, lowd_r, highd_r;
  logic signed [emos_pkg::RATING_W-1:0] ratd_r;
  logic [52:0]                          prodd_r;

  logic [13:0]                 m_w;
  logic [emos_pkg::MOS_W-1:0]  mos_nxt;

  logic            out_vld_r;
  emos_pkg::out_t  out_r;

  assign rr_w = in_rating[14:0];
  assign a_w  = $signed({1'b0, rr_w}) - emos_pkg::R_SIXTY_Q8;
  assign p1_w = 32'(a_w) * 32'($signed({1'b0, rr_w}));
  assign b_w  = emos_pkg::R_TOP_U16 - {1'b0, rr_w};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      va_r <= in_vld;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      out_vld_r <= vd_r;
    end
    lowa_r  <= in_rating[emos_pkg::RATING_W-1];
    higha_r <= (in_rating > emos_pkg::R_TOP_Q8);
    rata_r  <= in_rating;
    rra_r   <= rr_w;
    p1a_r   <= p1_w;
    ba_r    <= b_w;

    lowb_r  <= lowa_r;
    highb_r <= higha_r;
    ratb_r  <= rata_r;
    p2b_r   <= 48'(p1a_r) * 48'($signed({1'b0, ba_r}));
    linb_r  <= 46'(rra_r) * 46'(emos_pkg::MOS_LIN_K);

    lowc_r  <= lowb_r | (t_w[48] & ~highb_r);
    highc_r <= highb_r;
    ratc_r  <= ratb_r;
    vq_r    <= u_w[45:20];

    lowd_r  <= lowc_r;
    highd_r <= highc_r;
    ratd_r  <= ratc_r;
    prodd_r <= 53'(vq_r) * 53'(emos_pkg::MOS_RECIP);

    out_r.rating_q8 <= ratd_r;
    out_r.mos_q10   <= mos_nxt;
  end

  assign t_w = $signed({3'b000, linb_r}) + (49'(p2b_r) <<< 3) - 49'(p2b_r);
  assign u_w = t_w + $signed(49'(emos_pkg::MOS_HALF_DEN));

  assign m_w = 14'(prodd_r[52:40]) + 14'(emos_pkg::MOS_ONE_Q10);

  always_comb begin
    priority if (lowd_r) begin
      mos_nxt = emos_pkg::MOS_ONE_Q10;
    end else if (highd_r || (m_w > 14'(emos_pkg::MOS_TOP_Q10))) begin
      mos_nxt = emos_pkg::MOS_TOP_Q10;
    end else begin
      mos_nxt = m_w[emos_pkg::MOS_W-1:0];
    end
  end

  assign out_vld = out_vld_r;
  assign out_res = out_r;

endmodule

// File: design/emodel_mos_estimator_core.sv
// Top level of the E-model MOS estimator: config registers, impairment front end,
// rating sum. Depends on emos_pkg, emos_ie_div and emos_mos.
//
// Usage:
//   Input channel: drive in_data (delay_us, loss_frac_q16) with start high; the
//   item transfers at that rising edge. busy is always low, so an item may be
//   sent in every cycle.
//   Result channel: out_valid is high for exactly one cycle with out_data
//   (rating_q8, mos_q10). The receiver cannot stall, so none is needed.
//   Path from the accepting edge to out_valid: two front-end stages, the
//   divider (input register plus 15 stages, one quotient bit each), the rating
//   register and the five-stage MOS pipeline. Throughput: one item per cycle;
//   every stage advances each cycle.
//   Config port: cfg_we with cfg_idx and cfg_wdata writes one register at the
//   clock edge (0 Ie, 1 Bpl, 2 A, 3 Ro); write only while no item is in flight.
//   Reset (rst_n low, synchronous): registers take their default values and
//   all items in flight are dropped.
module emodel_mos_estimator_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  emos_pkg::in_t                    in_data,
  output logic                             out_valid,
  output emos_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [emos_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [emos_pkg::CFG_W-1:0]       cfg_wdata
);

  logic [emos_pkg::CFG_W-1:0] ie_r, bpl_r, ro_r;
  logic [12:0]                adv_r;

  logic [emos_pkg::DELAY_W-1:0] over_w;
  logic [29:0]                  dnum_w;
  logic [31:0]                  y_w;
  logic [emos_pkg::LOSS_W-1:0]  ls_w;
  logic [22:0]                  l_w;
  logic [emos_pkg::CFG_W-1:0]   bpl_w;
  logic [emos_pkg::DEN_W-1:0]   den_w;
  logic                         neg_w;
  logic [emos_pkg::CFG_W-1:0]   mag_w;

  logic                         v1_r, neg1_r;
  logic [31:0]                  y1_r;
  logic [22:0]                  l1_r;
  logic [emos_pkg::DEN_W-1:0]   den1_r;
  logic [emos_pkg::CFG_W-1:0]   mag1_r;

  logic [64:0]                  idp_w;
  logic                         v2_r, neg2_r;
  logic [emos_pkg::ID_W-1:0]    id2_r;
  logic [emos_pkg::NUM_W-1:0]   pm2_r;
  logic [emos_pkg::DEN_W-1:0]   den2_r;

  emos_pkg::div_tag_t           div_tag_in;
  logic                         div_vld;
  logic [emos_pkg::QUO_W-1:0]   div_quo;
  emos_pkg::div_tag_t           div_tag;

  logic signed [20:0]                   ieff_w, r_w;
  logic signed [emos_pkg::RATING_W-1:0] rating_nxt;
  logic                                 vr_r;
  logic signed [emos_pkg::RATING_W-1:0] rating_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ie_r  <= emos_pkg::IE_RESET;
      bpl_r <= emos_pkg::BPL_RESET;
      adv_r <= emos_pkg::ADV_RESET;
      ro_r  <= emos_pkg::RO_RESET;
    end else if (cfg_we) begin
      unique case (emos_pkg::cfg_idx_t'(cfg_idx))
        emos_pkg::CFG_EQUIP_IMP: ie_r  <= cfg_wdata;
        emos_pkg::CFG_LOSS_ROB:  bpl_r <= cfg_wdata;
        emos_pkg::CFG_ADVANTAGE: adv_r <= cfg_wdata[12:0];
        emos_pkg::CFG_BASE_RATE: ro_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    over_w = (in_data.delay_us > emos_pkg::KNEE_US) ?
             (in_data.delay_us - emos_pkg::KNEE_US) : '0;
    dnum_w = 30'(in_data.delay_us) * 30'd24 + 30'(over_w) * 30'd110;
    y_w    = {dnum_w, 2'b00} + emos_pkg::ID_ROUND;
    ls_w   = (in_data.loss_frac_q16 > emos_pkg::LOSS_FULL) ?
             emos_pkg::LOSS_FULL : in_data.loss_frac_q16;
    l_w    = 23'(ls_w) * 23'd100;
    bpl_w  = (bpl_r < emos_pkg::BPL_MIN_Q8) ? emos_pkg::BPL_MIN_Q8 : bpl_r;
    den_w  = 24'(l_w) + {1'b0, bpl_w, 8'h00};
    neg_w  = (ie_r > emos_pkg::IMP_CEIL_Q8);
    mag_w  = neg_w ? (ie_r - emos_pkg::IMP_CEIL_Q8) : (emos_pkg::IMP_CEIL_Q8 - ie_r);
  end

  assign idp_w = 65'(y1_r) * 65'(emos_pkg::ID_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vr_r <= 1'b0;
    end else begin
      v1_r <= start & ~busy;
      v2_r <= v1_r;
      vr_r <= div_vld;
    end
    y1_r   <= y_w;
    l1_r   <= l_w;
    den1_r <= den_w;
    mag1_r <= mag_w;
    neg1_r <= neg_w;

    id2_r  <= idp_w[63:46];
    pm2_r  <= 38'(mag1_r) * 38'(l1_r);
    den2_r <= den1_r;
    neg2_r <= neg1_r;

    rating_r <= rating_nxt;
  end

  assign div_tag_in.id_q8  = id2_r;
  assign div_tag_in.ie_neg = neg2_r;

  emos_ie_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v2_r),
    .in_num  (pm2_r + 38'(den2_r[emos_pkg::DEN_W-1:1])),
    .in_den  (den2_r),
    .in_tag  (div_tag_in),
    .out_vld (div_vld),
    .out_quo (div_quo),
    .out_tag (div_tag)
  );

  always_comb begin
    ieff_w = div_tag.ie_neg ? ($signed(21'(ie_r)) - $signed(21'(div_quo))) :
                              ($signed(21'(ie_r)) + $signed(21'(div_quo)));
    r_w    = $signed(21'(ro_r)) + $signed(21'(adv_r)) -
             $signed(21'(div_tag.id_q8)) - ieff_w;
    priority if (r_w < emos_pkg::RATING_MIN) begin
      rating_nxt = emos_pkg::RATING_MIN[emos_pkg::RATING_W-1:0];
    end else if (r_w > emos_pkg::RATING_MAX) begin
      rating_nxt = emos_pkg::RATING_MAX[emos_pkg::RATING_W-1:0];
    end else begin
      rating_nxt = r_w[emos_pkg::RATING_W-1:0];
    end
  end

  emos_mos u_mos (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (vr_r),
    .in_rating (rating_r),
    .out_vld   (out_valid),
    .out_res   (out_data)
  );

endmodule
